// ----- rtl/swcpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcpd_pkg
// Shared constants and types of the sliding window change point detector.
// ----------------------------------------------------------------------------
package swcpd_pkg;

   localparam int TRAIN_LEN    = 200;
   localparam int MON_LEN      = 50;
   localparam int STORE_DEPTH  = TRAIN_LEN + MON_LEN;
   localparam int SAMPLE_BITS  = 16;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS   = $clog2(TRAIN_LEN + 1);
   localparam int MON_BITS     = 6;
   localparam int Q1_BITS      = 24;
   localparam int S_BITS       = 40;
   localparam int Q2_BITS      = 22;
   localparam int DEV_BITS     = 30;
   localparam int VAR_BITS     = 48;
   localparam int MUL_A_BITS   = 80;
   localparam int MUL_B_BITS   = 32;
   localparam int THR_BITS     = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [THR_BITS-1:0] THR_RESET = 16'd2036;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_THRESHOLD = 3'd0;
   localparam int LHS_SCALE    = 256 * (TRAIN_LEN - 1);

   localparam logic [1:0] PHASE_DISCARD = 2'd0;
   localparam logic [1:0] PHASE_TRAIN   = 2'd1;
   localparam logic [1:0] PHASE_MON     = 2'd2;
   localparam logic [1:0] PHASE_HALT    = 2'd3;

   typedef struct packed {
      logic                  start;
      logic [MUL_A_BITS-1:0] a;
      logic [MUL_B_BITS-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [MUL_A_BITS-1:0] product;
   } mul_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/swcpd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcpd_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface swcpd_req_if import swcpd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface swcpd_rsp_if import swcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          phase;
   logic                alarm;
   logic [7:0]          alarm_position;
   logic [MON_BITS-1:0] monitor_index;
   logic                window_slid;
   modport source (output valid, output phase, output alarm, output alarm_position,
                   output monitor_index, output window_slid, input ready);
   modport sink (input valid, input phase, input alarm, input alarm_position,
                 input monitor_index, input window_slid, output ready);
endinterface
`default_nettype wire

// ----- rtl/swcpd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcpd_ram
// Generic simple dual port RAM with registered read data.
// ----------------------------------------------------------------------------
module swcpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire  [$clog2(DEPTH)-1:0] waddr,
   input  wire  [WIDTH-1:0]         wdata,
   input  wire  [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/swcpd_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcpd_mul
// Shift and add multiplier, one multiplier bit per cycle, stops early.
// ----------------------------------------------------------------------------
module swcpd_mul import swcpd_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   logic                  busy_ff, busy_in;
   logic [MUL_A_BITS-1:0] a_ff, a_in, acc_ff, acc_in;
   logic [MUL_B_BITS-1:0] b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         a_in    = cmd.a;
         b_in    = cmd.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done    = busy_ff && (b_ff == '0);
   assign rsp.product = acc_ff;

endmodule
`default_nettype wire

// ----- rtl/sliding_window_change_point_detector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_change_point_detector
// CUSUM style change point test over a sliding training window.
//
//   channel  direction  handshake            payload
//   req_chan in         valid/ready          sample
//   rsp_chan out        valid/ready          phase, alarm, alarm_position,
//                                            monitor_index, window_slid
//   apb      in         psel/penable/pready  threshold_squared_q8
//
// Halted and first items go straight to the result; training items take
// a 16-bit square on the shift-add multiplier, monitoring items take nine
// multiplications on that multiplier, one multiplier bit a cycle.
// A window slide re-walks the 200 training entries of the 250-entry store.
// Reset is synchronous; the store needs no clearing. A held result blocks
// only the next result; a new item is taken while it waits.
// ----------------------------------------------------------------------------
module sliding_window_change_point_detector import swcpd_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   swcpd_req_if.sink                 req_chan,
   swcpd_rsp_if.source               rsp_chan,
   input  wire                       psel,
   input  wire                       penable,
   input  wire                       pwrite,
   input  wire  [CSR_ADDR_BITS-1:0]  paddr,
   input  wire  [CSR_DATA_BITS-1:0]  pwdata,
   output logic [CSR_DATA_BITS-1:0]  prdata,
   output logic                      pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TRAIN_START, ST_TRAIN_WAIT, ST_TEST_START, ST_TEST_WAIT,
      ST_DECIDE, ST_RB_READ, ST_RB_START, ST_RB_WAIT, ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_MQ2, OP_IQ1, OP_MS, OP_Q1SQ, OP_NSQ, OP_LHS, OP_TMI, OP_TMI2, OP_RHS
   } op_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [COUNT_BITS-1:0]   k_ff, k_in, fill_ff, fill_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic                    halted_ff, halted_in, first_ff, first_in;
   logic [MON_BITS-1:0]     mc_ff, mc_in;
   logic [ADDR_BITS-1:0]    base_ff, base_in;
   logic [Q1_BITS-1:0]      q1_ff, q1_in;
   logic [S_BITS-1:0]       s_ff, s_in;
   logic [Q2_BITS-1:0]      q2_ff, q2_in;
   logic [DEV_BITS-1:0]     am_ff, am_in, n_ff, n_in;
   logic [VAR_BITS-1:0]     ms_ff, ms_in, d_ff, d_in;
   logic [MUL_A_BITS-1:0]   t_ff, t_in, lhs_ff, lhs_in;
   logic [THR_BITS-1:0]     thr_ff, thr_in;
   logic [1:0]              res_phase_ff, res_phase_in;
   logic                    res_alarm_ff, res_alarm_in, res_slid_ff, res_slid_in;
   logic [7:0]              res_pos_ff, res_pos_in;
   logic [MON_BITS-1:0]     res_idx_ff, res_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_phase_ff, rsp_phase_in;
   logic                    rsp_alarm_ff, rsp_alarm_in, rsp_slid_ff, rsp_slid_in;
   logic [7:0]              rsp_pos_ff, rsp_pos_in;
   logic [MON_BITS-1:0]     rsp_idx_ff, rsp_idx_in;

   logic                    accept;
   logic                    ram_we;
   logic [ADDR_BITS-1:0]    ram_waddr, ram_raddr;
   logic [SAMPLE_BITS-1:0]  ram_rdata;
   logic [ADDR_BITS:0]      wsum, rsum, bsum;
   logic [ADDR_BITS+1:0]    msum;
   logic [7:0]              mi;
   mul_cmd_type             mcmd;
   mul_rsp_type             mrsp;
   logic [MUL_A_BITS-1:0]   p;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign p              = mrsp.product;
   assign mi             = 8'(TRAIN_LEN) + 8'(mc_ff);

   assign wsum      = (ADDR_BITS+1)'(base_ff) + (ADDR_BITS+1)'(fill_ff);
   assign msum      = (ADDR_BITS+2)'(base_ff) + (ADDR_BITS+2)'(TRAIN_LEN)
                      + (ADDR_BITS+2)'(mc_ff);
   assign rsum      = (ADDR_BITS+1)'(base_ff) + (ADDR_BITS+1)'(k_ff);
   assign bsum      = (ADDR_BITS+1)'(base_ff) + (ADDR_BITS+1)'(MON_LEN);
   assign ram_raddr = (rsum >= (ADDR_BITS+1)'(STORE_DEPTH))
                      ? ADDR_BITS'(rsum - (ADDR_BITS+1)'(STORE_DEPTH)) : ADDR_BITS'(rsum);

   always_comb begin
      ram_we    = accept && !halted_ff && first_ff;
      ram_waddr = '0;
      if (fill_ff < COUNT_BITS'(TRAIN_LEN)) begin
         ram_waddr = (wsum >= (ADDR_BITS+1)'(STORE_DEPTH))
                     ? ADDR_BITS'(wsum - (ADDR_BITS+1)'(STORE_DEPTH)) : ADDR_BITS'(wsum);
      end else begin
         ram_waddr = (msum >= (ADDR_BITS+2)'(STORE_DEPTH))
                     ? ADDR_BITS'(msum - (ADDR_BITS+2)'(STORE_DEPTH)) : ADDR_BITS'(msum);
      end
   end

   swcpd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_chan.sample),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      mcmd.start = (state_ff == ST_TRAIN_START) || (state_ff == ST_TEST_START)
                   || (state_ff == ST_RB_START);
      mcmd.a     = MUL_A_BITS'(sample_ff);
      mcmd.b     = MUL_B_BITS'(sample_ff);
      if (state_ff == ST_RB_START) begin
         mcmd.a = MUL_A_BITS'(ram_rdata);
         mcmd.b = MUL_B_BITS'(ram_rdata);
      end else if (state_ff == ST_TEST_START) begin
         case (op_ff)
            OP_MQ2: begin
               mcmd.a = MUL_A_BITS'(q2_ff);
               mcmd.b = MUL_B_BITS'(TRAIN_LEN);
            end
            OP_IQ1: begin
               mcmd.a = MUL_A_BITS'(q1_ff);
               mcmd.b = MUL_B_BITS'(mc_ff);
            end
            OP_MS: begin
               mcmd.a = MUL_A_BITS'(s_ff);
               mcmd.b = MUL_B_BITS'(TRAIN_LEN);
            end
            OP_Q1SQ: begin
               mcmd.a = MUL_A_BITS'(q1_ff);
               mcmd.b = MUL_B_BITS'(q1_ff);
            end
            OP_NSQ: begin
               mcmd.a = MUL_A_BITS'(n_ff);
               mcmd.b = MUL_B_BITS'(n_ff);
            end
            OP_LHS: begin
               mcmd.a = t_ff;
               mcmd.b = MUL_B_BITS'(LHS_SCALE);
            end
            OP_TMI: begin
               mcmd.a = MUL_A_BITS'(thr_ff);
               mcmd.b = MUL_B_BITS'(mi);
            end
            OP_TMI2: begin
               mcmd.a = t_ff;
               mcmd.b = MUL_B_BITS'(mi);
            end
            OP_RHS: begin
               mcmd.a = MUL_A_BITS'(d_ff);
               mcmd.b = t_ff[MUL_B_BITS-1:0];
            end
            default: begin
               mcmd.a = '0;
               mcmd.b = '0;
            end
         endcase
      end
   end

   swcpd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mcmd),
      .rsp   (mrsp)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      fill_in      = fill_ff;
      sample_in    = sample_ff;
      halted_in    = halted_ff;
      first_in     = first_ff;
      mc_in        = mc_ff;
      base_in      = base_ff;
      q1_in        = q1_ff;
      s_in         = s_ff;
      q2_in        = q2_ff;
      am_in        = am_ff;
      n_in         = n_ff;
      ms_in        = ms_ff;
      d_in         = d_ff;
      t_in         = t_ff;
      lhs_in       = lhs_ff;
      thr_in       = thr_ff;
      res_phase_in = res_phase_ff;
      res_alarm_in = res_alarm_ff;
      res_slid_in  = res_slid_ff;
      res_pos_in   = res_pos_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_phase_in = rsp_phase_ff;
      rsp_alarm_in = rsp_alarm_ff;
      rsp_slid_in  = rsp_slid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_idx_in   = rsp_idx_ff;

      if (psel && penable && pwrite && pready && (paddr[CSR_ADDR_BITS-1:2] ==
          CSR_THRESHOLD[CSR_ADDR_BITS-1:2])) begin
         thr_in = pwdata[THR_BITS-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in    = req_chan.sample;
               res_alarm_in = 1'b0;
               res_slid_in  = 1'b0;
               res_pos_in   = '0;
               res_idx_in   = '0;
               if (halted_ff) begin
                  res_phase_in = PHASE_HALT;
                  state_in     = ST_FINISH;
               end else if (!first_ff) begin
                  first_in     = 1'b1;
                  res_phase_in = PHASE_DISCARD;
                  state_in     = ST_FINISH;
               end else if (fill_ff < COUNT_BITS'(TRAIN_LEN)) begin
                  res_phase_in = PHASE_TRAIN;
                  state_in     = ST_TRAIN_START;
               end else begin
                  mc_in        = mc_ff + 1'b1;
                  q2_in        = q2_ff + Q2_BITS'(req_chan.sample);
                  res_phase_in = PHASE_MON;
                  res_idx_in   = mc_ff + 1'b1;
                  op_in        = OP_MQ2;
                  state_in     = ST_TEST_START;
               end
            end
         end
         ST_TRAIN_START: begin
            state_in = ST_TRAIN_WAIT;
         end
         ST_TRAIN_WAIT: begin
            if (mrsp.done) begin
               q1_in    = q1_ff + Q1_BITS'(sample_ff);
               s_in     = s_ff + S_BITS'(p[2*SAMPLE_BITS-1:0]);
               fill_in  = fill_ff + 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_TEST_START: begin
            state_in = ST_TEST_WAIT;
         end
         ST_TEST_WAIT: begin
            if (mrsp.done) begin
               state_in = ST_TEST_START;
               op_in    = op_type'(op_ff + 1'b1);
               case (op_ff)
                  OP_MQ2:  am_in = p[DEV_BITS-1:0];
                  OP_IQ1:  n_in  = (am_ff >= p[DEV_BITS-1:0]) ? am_ff - p[DEV_BITS-1:0]
                                                             : p[DEV_BITS-1:0] - am_ff;
                  OP_MS:   ms_in = p[VAR_BITS-1:0];
                  OP_Q1SQ: d_in  = (ms_ff >= p[VAR_BITS-1:0]) ? ms_ff - p[VAR_BITS-1:0]
                                                             : '0;
                  OP_NSQ:  t_in   = p;
                  OP_LHS:  lhs_in = p;
                  OP_TMI:  t_in   = p;
                  OP_TMI2: t_in   = p;
                  OP_RHS: begin
                     res_alarm_in = !((n_ff == '0) && (d_ff == '0)) && (lhs_ff >= p);
                     state_in     = ST_DECIDE;
                  end
                  default: state_in = ST_DECIDE;
               endcase
            end
         end
         ST_DECIDE: begin
            if (res_alarm_ff) begin
               halted_in  = 1'b1;
               res_pos_in = 8'(TRAIN_LEN + 1) + 8'(mc_ff);
               state_in   = ST_FINISH;
            end else if (mc_ff >= MON_BITS'(MON_LEN)) begin
               base_in     = (bsum >= (ADDR_BITS+1)'(STORE_DEPTH))
                             ? ADDR_BITS'(bsum - (ADDR_BITS+1)'(STORE_DEPTH))
                             : ADDR_BITS'(bsum);
               q1_in       = '0;
               s_in        = '0;
               q2_in       = '0;
               mc_in       = '0;
               k_in        = '0;
               res_slid_in = 1'b1;
               state_in    = ST_RB_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RB_READ: begin
            state_in = ST_RB_START;
         end
         ST_RB_START: begin
            q1_in    = q1_ff + Q1_BITS'(ram_rdata);
            state_in = ST_RB_WAIT;
         end
         ST_RB_WAIT: begin
            if (mrsp.done) begin
               s_in = s_ff + S_BITS'(p[2*SAMPLE_BITS-1:0]);
               k_in = k_ff + 1'b1;
               if (k_ff == COUNT_BITS'(TRAIN_LEN - 1)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_RB_READ;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = res_phase_ff;
               rsp_alarm_in = res_alarm_ff;
               rsp_slid_in  = res_slid_ff;
               rsp_pos_in   = res_pos_ff;
               rsp_idx_in   = res_idx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_MQ2;
         fill_ff      <= '0;
         halted_ff    <= 1'b0;
         first_ff     <= 1'b0;
         mc_ff        <= '0;
         base_ff      <= '0;
         q1_ff        <= '0;
         s_ff         <= '0;
         q2_ff        <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         fill_ff      <= fill_in;
         halted_ff    <= halted_in;
         first_ff     <= first_in;
         mc_ff        <= mc_in;
         base_ff      <= base_in;
         q1_ff        <= q1_in;
         s_ff         <= s_in;
         q2_ff        <= q2_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      sample_ff    <= sample_in;
      am_ff        <= am_in;
      n_ff         <= n_in;
      ms_ff        <= ms_in;
      d_ff         <= d_in;
      t_ff         <= t_in;
      lhs_ff       <= lhs_in;
      res_phase_ff <= res_phase_in;
      res_alarm_ff <= res_alarm_in;
      res_slid_ff  <= res_slid_in;
      res_pos_ff   <= res_pos_in;
      res_idx_ff   <= res_idx_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_alarm_ff <= rsp_alarm_in;
      rsp_slid_ff  <= rsp_slid_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.phase          = rsp_phase_ff;
   assign rsp_chan.alarm          = rsp_alarm_ff;
   assign rsp_chan.window_slid    = rsp_slid_ff;
   assign rsp_chan.alarm_position = rsp_pos_ff;
   assign rsp_chan.monitor_index  = rsp_idx_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_BITS-1:2] == CSR_THRESHOLD[CSR_ADDR_BITS-1:2])
                   ? CSR_DATA_BITS'(thr_ff) : '0;

`ifndef ASSERT_OFF
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted state cleared");

   a_alarm_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_alarm_ff) |-> (rsp_phase_ff == PHASE_MON))
      else $error("alarm outside monitoring");

   a_slid_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_slid_ff && rsp_alarm_ff))
      else $error("slide together with alarm");

   a_mon_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && !halted_ff) |-> (mc_ff < MON_BITS'(MON_LEN)))
      else $error("monitor count past window");
`endif

endmodule
`default_nettype wire
